/* hdl/utf8_stream_validator_assert.svh */
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UTF8SV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define UTF8SV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hdl/utf8sv_pkg.sv */
package utf8sv_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int OFFSET_OUT_BITS = 16;
   localparam int RSP_FIELD_BITS = 6 + OFFSET_OUT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = {OFFSET_BITS{1'b1}};

   localparam logic [2:0] ERR_NONE  = 3'd0;
   localparam logic [2:0] ERR_LEAD  = 3'd1;
   localparam logic [2:0] ERR_CONT  = 3'd2;
   localparam logic [2:0] ERR_TRUNC = 3'd3;
   localparam logic [2:0] ERR_ZERO  = 3'd4;

   localparam logic [1:0] CLASS_PLAIN = 2'd0;
   localparam logic [1:0] CLASS_E0    = 2'd1;
   localparam logic [1:0] CLASS_F0    = 2'd2;
   localparam logic [1:0] CLASS_F4    = 2'd3;

   localparam logic [7:0] BYTE_ZERO    = 8'h00;
   localparam logic [7:0] BYTE_TAB     = 8'h09;
   localparam logic [7:0] BYTE_LF      = 8'h0A;
   localparam logic [7:0] BYTE_CR      = 8'h0D;
   localparam logic [7:0] BYTE_SPACE   = 8'h20;
   localparam logic [7:0] BYTE_DEL     = 8'h7F;
   localparam logic [7:0] BYTE_CONT_LO = 8'h80;
   localparam logic [7:0] BYTE_CONT_HI = 8'hBF;
   localparam logic [7:0] BYTE_MB_LO   = 8'hC0;
   localparam logic [7:0] BYTE_LEAD2   = 8'hC2;
   localparam logic [7:0] BYTE_LEAD2_HI = 8'hDF;
   localparam logic [7:0] BYTE_E0      = 8'hE0;
   localparam logic [7:0] BYTE_LEAD3_HI = 8'hEF;
   localparam logic [7:0] BYTE_F0      = 8'hF0;
   localparam logic [7:0] BYTE_F4      = 8'hF4;
   localparam logic [7:0] BYTE_A0      = 8'hA0;
   localparam logic [7:0] BYTE_90      = 8'h90;
   localparam logic [7:0] BYTE_8F      = 8'h8F;

   typedef struct packed {
      logic [1:0]             pending;
      logic [1:0]             lead_class;
      logic                   first_cont;
      logic                   mb_seen;
      logic [2:0]             err;
      logic [OFFSET_BITS-1:0] err_pos;
      logic [OFFSET_BITS-1:0] pos;
   } state_type;

   typedef struct packed {
      logic [OFFSET_OUT_BITS-1:0] error_offset;
      logic [2:0]                 error_kind;
      logic                       saw_multibyte;
      logic                       well_formed;
      logic                       string_accepted;
   } result_type;

   // Map an offset of any width onto the 16-bit result field.
   function automatic logic [OFFSET_OUT_BITS-1:0] to_offset_out(
      input logic [OFFSET_BITS-1:0] p);
      logic [31:0] wide;
      begin
         wide = 32'(p);
         return wide[OFFSET_OUT_BITS-1:0];
      end
   endfunction

endpackage

/* hdl/utf8sv_step.sv */
module utf8sv_step (
   input  utf8sv_pkg::state_type  cur_state,
   input  logic [7:0]             data_byte,
   input  logic                   last_byte,
   input  logic                   require_multibyte,
   output utf8sv_pkg::state_type  nxt_state,
   output utf8sv_pkg::result_type result
);
   import utf8sv_pkg::*;

   state_type upd;
   logic      cont_ok;
   logic      wf;

   always_comb begin
      upd = cur_state;
      cont_ok = 1'b0;
      if (cur_state.err == ERR_NONE) begin
         if (cur_state.pending == 2'd0) begin
            if (data_byte >= BYTE_MB_LO) begin
               upd.mb_seen = 1'b1;
            end
            if (data_byte == BYTE_ZERO) begin
               upd.err = ERR_ZERO;
               upd.err_pos = cur_state.pos;
            end else if (data_byte == BYTE_TAB || data_byte == BYTE_LF ||
                         data_byte == BYTE_CR ||
                         (data_byte >= BYTE_SPACE && data_byte <= BYTE_DEL)) begin
               upd.pending = 2'd0;
            end else if (data_byte >= BYTE_LEAD2 && data_byte <= BYTE_LEAD2_HI) begin
               upd.pending = 2'd1;
               upd.lead_class = CLASS_PLAIN;
               upd.first_cont = 1'b1;
            end else if (data_byte >= BYTE_E0 && data_byte <= BYTE_LEAD3_HI) begin
               upd.pending = 2'd2;
               upd.lead_class = (data_byte == BYTE_E0) ? CLASS_E0 : CLASS_PLAIN;
               upd.first_cont = 1'b1;
            end else if (data_byte >= BYTE_F0 && data_byte <= BYTE_F4) begin
               upd.pending = 2'd3;
               upd.lead_class = (data_byte == BYTE_F0) ? CLASS_F0 :
                                (data_byte == BYTE_F4) ? CLASS_F4 : CLASS_PLAIN;
               upd.first_cont = 1'b1;
            end else begin
               upd.err = ERR_LEAD;
               upd.err_pos = cur_state.pos;
            end
         end else if (data_byte == BYTE_ZERO) begin
            upd.err = ERR_ZERO;
            upd.err_pos = cur_state.pos;
         end else begin
            cont_ok = (data_byte >= BYTE_CONT_LO) && (data_byte <= BYTE_CONT_HI);
            if (cur_state.first_cont) begin
               case (cur_state.lead_class)
                  CLASS_E0: if (data_byte < BYTE_A0) cont_ok = 1'b0;
                  CLASS_F0: if (data_byte < BYTE_90) cont_ok = 1'b0;
                  CLASS_F4: if (data_byte > BYTE_8F) cont_ok = 1'b0;
                  default: ;
               endcase
            end
            if (!cont_ok) begin
               upd.err = ERR_CONT;
               upd.err_pos = cur_state.pos;
            end else begin
               upd.first_cont = 1'b0;
               upd.pending = cur_state.pending - 2'd1;
               if (cur_state.pending == 2'd1) begin
                  upd.lead_class = CLASS_PLAIN;
               end
            end
         end
      end

      // Flag a sequence cut off by the end of the string.
      if (last_byte && upd.err == ERR_NONE && upd.pending != 2'd0) begin
         upd.err = ERR_TRUNC;
         upd.err_pos = cur_state.pos;
      end

      if (cur_state.pos != POS_MAX) begin
         upd.pos = cur_state.pos + 1'b1;
      end

      wf = (upd.err == ERR_NONE);
      result.string_accepted = wf & (upd.mb_seen | ~require_multibyte);
      result.well_formed = wf;
      result.saw_multibyte = upd.mb_seen;
      result.error_kind = upd.err;
      result.error_offset = wf ? '0 : to_offset_out(upd.err_pos);

      nxt_state = last_byte ? '0 : upd;
   end

endmodule

/* hdl/utf8sv_rsp_reg.sv */
module utf8sv_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  utf8sv_pkg::result_type load_data,
   output logic                   slot_free,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [utf8sv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import utf8sv_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff;

   assign slot_free = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the word until the sink takes it.
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = RSP_TDATA_BITS'(data_ff);

endmodule

/* hdl/utf8_stream_validator.sv */
// UTF-8 stream validator. Takes one string byte per word on the req side
// (tlast marks the final byte) and returns one verdict word on the rsp side
// for each string, loaded once its last byte leaves the input register. Bytes
// are accepted back to back at one per cycle; the decode of a byte against
// the carried state is combinational between the input register and the
// result register, and req_tready drops only while a finished verdict waits
// in the result register and the next last byte is ready to produce another.
// The first error and its byte offset are kept; state clears after each
// verdict. csr_wdata written with csr_we sets require_multibyte (reset 1);
// write it only while no string is in flight.
module utf8_stream_validator (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   // [0] string_accepted, [1] well_formed, [2] saw_multibyte,
   // [5:3] error_kind, [21:6] error_offset, [23:22] zero
   output logic [utf8sv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic       csr_we,
   input  logic       csr_wdata
);
   import utf8sv_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       req_mb_ff, req_mb_in;
   state_type  state_ff, state_in, step_state;
   result_type step_result;
   logic       slot_free;
   logic       fire;
   logic       accept;

   // Advance the input word unless its verdict has nowhere to go.
   assign fire = in_valid_ff && (!in_last_ff || slot_free);
   assign req_tready = !in_valid_ff || fire;
   assign accept = req_tvalid && req_tready;
   assign in_valid_in = accept || (in_valid_ff && !fire);
   assign state_in = fire ? step_state : state_ff;
   assign req_mb_in = csr_we ? csr_wdata : req_mb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff <= '0;
         req_mb_ff <= 1'b1;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff <= state_in;
         req_mb_ff <= req_mb_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   utf8sv_step u_step (
      .cur_state         (state_ff),
      .data_byte         (in_byte_ff),
      .last_byte         (in_last_ff),
      .require_multibyte (req_mb_ff),
      .nxt_state         (step_state),
      .result            (step_result)
   );

   utf8sv_rsp_reg u_rsp_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && in_last_ff),
      .load_data  (step_result),
      .slot_free  (slot_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* hdl/utf8sv_checker.sv */
`include "utf8_stream_validator_assert.svh"

module utf8sv_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [utf8sv_pkg::RSP_TDATA_BITS-1:0] rsp_tdata
);
   import utf8sv_pkg::*;

   `UTF8SV_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "rsp word changed while stalled")
   `UTF8SV_ASSERT_NOW(a_accept_wf, clock, reset, rsp_tvalid, !rsp_tdata[0] || rsp_tdata[1], "string accepted but not well formed")
   `UTF8SV_ASSERT_NOW(a_wf_kind, clock, reset, rsp_tvalid, rsp_tdata[1] == (rsp_tdata[5:3] == ERR_NONE), "well_formed disagrees with error kind")
   `UTF8SV_ASSERT_NOW(a_wf_offset, clock, reset, rsp_tvalid && rsp_tdata[1], rsp_tdata[21:6] == '0, "error offset set on a clean string")
   `UTF8SV_ASSERT_NOW(a_kind_range, clock, reset, rsp_tvalid, rsp_tdata[5:3] <= ERR_ZERO, "error kind out of range")

endmodule

bind utf8_stream_validator utf8sv_checker u_checker (.*);

/* bench/tb_top.sv */
module tb_top;
   import utf8sv_pkg::*;

   localparam int ITEMS_PER_PHASE = 360;
   localparam int HOLD_CYCLES     = 300;
   localparam int DRAIN_CYCLES    = 10;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int MAX_REPORTS     = 10;
   localparam int DIR_ROWS        = 25;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [7:0]                req_tdata;   // [7:0] data_byte
   logic                      req_tlast;   // last_byte
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // [0] string_accepted, [1] well_formed, [2] saw_multibyte,
   // [5:3] error_kind, [21:6] error_offset, [23:22] zero
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_we;
   logic                      csr_wdata;

   utf8_stream_validator u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       typed;
      result_type verdict;
   } dir_row_type;

   // Typed verdicts are for reset mode (multibyte required).
   dir_row_type dir_table [DIR_ROWS] = '{
      '{8'h41, 1'b1, 1'b1, '{16'd0, ERR_NONE,  1'b0, 1'b1, 1'b0}},
      '{8'h00, 1'b1, 1'b1, '{16'd0, ERR_ZERO,  1'b0, 1'b0, 1'b0}},
      '{8'hFF, 1'b1, 1'b1, '{16'd0, ERR_LEAD,  1'b1, 1'b0, 1'b0}},
      '{8'hC2, 1'b1, 1'b1, '{16'd0, ERR_TRUNC, 1'b1, 1'b0, 1'b0}},
      '{8'hC2, 1'b0, 1'b0, '0},
      '{8'h80, 1'b1, 1'b0, '0},
      '{8'hE0, 1'b0, 1'b0, '0},
      '{8'h9F, 1'b1, 1'b0, '0},
      '{8'hE0, 1'b0, 1'b0, '0},
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b1, 1'b0, '0},
      '{8'hF4, 1'b0, 1'b0, '0},
      '{8'h90, 1'b1, 1'b0, '0},
      '{8'hF0, 1'b0, 1'b0, '0},
      '{8'h90, 1'b0, 1'b0, '0},
      '{8'h80, 1'b0, 1'b0, '0},
      '{8'hBF, 1'b1, 1'b0, '0},
      '{8'hED, 1'b0, 1'b0, '0},
      '{8'hA0, 1'b0, 1'b0, '0},
      '{8'h00, 1'b1, 1'b0, '0},
      '{8'h09, 1'b0, 1'b0, '0},
      '{8'h0A, 1'b0, 1'b0, '0},
      '{8'h0D, 1'b0, 1'b0, '0},
      '{8'hC1, 1'b1, 1'b0, '0},
      '{8'h80, 1'b1, 1'b1, '{16'd0, ERR_LEAD,  1'b0, 1'b0, 1'b0}}
   };

   // decoder model state
   logic                   need_multibyte;
   logic [1:0]             conts_due;
   logic [1:0]             lead_kind;
   logic                   first_cont;
   logic                   mb_seen;
   logic [2:0]             str_err;
   logic [OFFSET_BITS-1:0] str_err_pos;
   logic [OFFSET_BITS-1:0] str_pos;

   result_type verdict_q[$];
   logic [7:0] str_buf[$];
   int         send_gap_max;
   int         recv_stall_max;
   bit         hold_request;
   int         phase_bytes;
   int         fault_count;
   int         cycle_count;

   function automatic void clear_string();
      conts_due   = 2'd0;
      lead_kind   = CLASS_PLAIN;
      first_cont  = 1'b0;
      mb_seen     = 1'b0;
      str_err     = ERR_NONE;
      str_err_pos = '0;
      str_pos     = '0;
   endfunction

   function automatic void note_error(input logic [2:0] kind);
      if (str_err == ERR_NONE) begin
         str_err     = kind;
         str_err_pos = str_pos;
      end
   endfunction

   // Advance the decoder by one byte; returns 1 with the verdict on a last byte.
   function automatic bit predict_verdict(input logic [7:0] b, input logic last,
                                          output result_type v);
      logic ok;
      v = '0;
      if (str_err == ERR_NONE) begin
         if (conts_due == 2'd0) begin
            if (b >= 8'hC0) mb_seen = 1'b1;
            if (b == 8'h00) begin
               note_error(ERR_ZERO);
            end else if (b == 8'h09 || b == 8'h0A || b == 8'h0D ||
                         (b >= 8'h20 && b <= 8'h7F)) begin
               ok = 1'b1;
            end else if (b >= 8'hC2 && b <= 8'hDF) begin
               conts_due  = 2'd1;
               lead_kind  = CLASS_PLAIN;
               first_cont = 1'b1;
            end else if (b >= 8'hE0 && b <= 8'hEF) begin
               conts_due  = 2'd2;
               lead_kind  = (b == 8'hE0) ? CLASS_E0 : CLASS_PLAIN;
               first_cont = 1'b1;
            end else if (b >= 8'hF0 && b <= 8'hF4) begin
               conts_due  = 2'd3;
               lead_kind  = (b == 8'hF0) ? CLASS_F0 :
                            (b == 8'hF4) ? CLASS_F4 : CLASS_PLAIN;
               first_cont = 1'b1;
            end else begin
               note_error(ERR_LEAD);
            end
         end else if (b == 8'h00) begin
            note_error(ERR_ZERO);
         end else begin
            ok = (b >= 8'h80 && b <= 8'hBF);
            if (ok && first_cont) begin
               if (lead_kind == CLASS_E0 && b < 8'hA0) ok = 1'b0;
               if (lead_kind == CLASS_F0 && b < 8'h90) ok = 1'b0;
               if (lead_kind == CLASS_F4 && b > 8'h8F) ok = 1'b0;
            end
            if (!ok) begin
               note_error(ERR_CONT);
            end else begin
               first_cont = 1'b0;
               conts_due  = conts_due - 2'd1;
               if (conts_due == 2'd0) lead_kind = CLASS_PLAIN;
            end
         end
      end
      if (last && str_err == ERR_NONE && conts_due != 2'd0) note_error(ERR_TRUNC);
      if (str_pos != '1) str_pos = str_pos + 1'b1;
      if (!last) return 1'b0;
      v.well_formed     = (str_err == ERR_NONE);
      v.saw_multibyte   = mb_seen;
      v.string_accepted = v.well_formed & (mb_seen | ~need_multibyte);
      v.error_kind      = str_err;
      v.error_offset    = v.well_formed ? '0 : 16'(str_err_pos);
      clear_string();
      return 1'b1;
   endfunction

   // Favor the range ends.
   function automatic logic [7:0] pick_biased(input int lo, input int hi);
      int r;
      r = $urandom_range(0, 3);
      if (r == 0) return 8'(lo);
      if (r == 1) return 8'(hi);
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic void add_char(input int width);
      logic [7:0] lead;
      int         r;
      case (width)
         0: begin
            r = $urandom_range(0, 9);
            if (r == 0)      str_buf.push_back(8'h09);
            else if (r == 1) str_buf.push_back(8'h0A);
            else if (r == 2) str_buf.push_back(8'h0D);
            else             str_buf.push_back(pick_biased(8'h20, 8'h7F));
         end
         1: begin
            str_buf.push_back(pick_biased(8'hC2, 8'hDF));
            str_buf.push_back(pick_biased(8'h80, 8'hBF));
         end
         2: begin
            lead = pick_biased(8'hE0, 8'hEF);
            str_buf.push_back(lead);
            str_buf.push_back(pick_biased((lead == 8'hE0) ? 8'hA0 : 8'h80, 8'hBF));
            str_buf.push_back(pick_biased(8'h80, 8'hBF));
         end
         default: begin
            lead = pick_biased(8'hF0, 8'hF4);
            str_buf.push_back(lead);
            str_buf.push_back(pick_biased((lead == 8'hF0) ? 8'h90 : 8'h80,
                                          (lead == 8'hF4) ? 8'h8F : 8'hBF));
            str_buf.push_back(pick_biased(8'h80, 8'hBF));
            str_buf.push_back(pick_biased(8'h80, 8'hBF));
         end
      endcase
   endfunction

   // Mostly well-formed strings, some corrupted or cut short, some pure noise.
   function automatic void build_string();
      int r;
      int n;
      int idx;
      str_buf.delete();
      r = $urandom_range(0, 99);
      if (r < 20) begin
         n = $urandom_range(1, 6);
         repeat (n) str_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         n = $urandom_range(1, 8);
         repeat (n) add_char($urandom_range(0, 3));
         r   = $urandom_range(0, 9);
         idx = $urandom_range(0, str_buf.size() - 1);
         if (r == 5 || r == 6) begin
            str_buf[idx] = 8'($urandom_range(0, 255));
         end else if (r == 7) begin
            str_buf[idx] = 8'h00;
         end else if (r >= 8 && str_buf.size() > 1) begin
            n = $urandom_range(1, str_buf.size() - 1);
            while (str_buf.size() > n) void'(str_buf.pop_back());
         end
      end
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic last,
                            input logic typed, input result_type typed_v);
      int         gap;
      result_type v;
      gap = $urandom_range(0, send_gap_max);
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tlast  = last;
      do @(posedge clock); while (!req_tready);
      if (predict_verdict(b, last, v)) verdict_q.push_back(typed ? typed_v : v);
      phase_bytes++;
   endtask

   task automatic send_strings(input int budget);
      phase_bytes = 0;
      while (phase_bytes < budget) begin
         build_string();
         foreach (str_buf[i]) send_byte(str_buf[i], i == str_buf.size() - 1, 1'b0, '0);
      end
   endtask

   // Wait for the block to go idle, then write the mode register.
   task automatic write_mode(input logic value);
      @(negedge clock);
      req_tvalid = 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_wdata = value;
      @(negedge clock);
      csr_we    = 1'b0;
      need_multibyte = value;
   endtask

   task automatic report_fault(input string what, input result_type want,
                               input result_type got);
      fault_count++;
      if (fault_count <= MAX_REPORTS)
         $display("%s: want acc=%0d wf=%0d mb=%0d kind=%0d off=%0d, got acc=%0d wf=%0d mb=%0d kind=%0d off=%0d pad=%b",
                  what, want.string_accepted, want.well_formed, want.saw_multibyte,
                  want.error_kind, want.error_offset, got.string_accepted,
                  got.well_formed, got.saw_multibyte, got.error_kind, got.error_offset,
                  rsp_tdata[RSP_TDATA_BITS-1:RSP_FIELD_BITS]);
   endtask

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("[utf8_stream_validator] ERROR");
      $finish;
   end

   // result side
   initial begin
      int         stall;
      result_type got;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            @(negedge clock);
            rsp_tready = 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         stall = $urandom_range(0, recv_stall_max);
         @(negedge clock);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         got = result_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
         if (verdict_q.size() == 0)
            report_fault("unexpected verdict", '0, got);
         else if (got !== verdict_q[0] ||
                  rsp_tdata[RSP_TDATA_BITS-1:RSP_FIELD_BITS] !== '0)
            report_fault("verdict mismatch", verdict_q.pop_front(), got);
         else
            void'(verdict_q.pop_front());
      end
   end

   initial begin
      cycle_count    = 0;
      fault_count    = 0;
      hold_request   = 1'b0;
      send_gap_max   = 10;
      recv_stall_max = 10;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      req_tlast      = 1'b0;
      rsp_tready     = 1'b0;
      csr_we         = 1'b0;
      csr_wdata      = 1'b0;
      need_multibyte = 1'b1;
      clear_string();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_table[i])
         send_byte(dir_table[i].data, dir_table[i].last, dir_table[i].typed,
                   dir_table[i].verdict);
      send_strings(ITEMS_PER_PHASE);

      // back to back on both sides, with one long receiver hold-off
      write_mode(1'b0);
      send_gap_max   = 0;
      recv_stall_max = 0;
      hold_request   = 1'b1;
      send_strings(ITEMS_PER_PHASE);

      write_mode(1'b1);
      send_gap_max   = 10;
      recv_stall_max = 0;
      send_strings(ITEMS_PER_PHASE);

      write_mode(1'b0);
      send_gap_max   = 0;
      recv_stall_max = 10;
      send_strings(ITEMS_PER_PHASE);

      @(negedge clock);
      req_tvalid = 1'b0;
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fault_count == 0)
         $display("[utf8_stream_validator] OK");
      else
         $display("[utf8_stream_validator] ERROR");
      $finish;
   end

endmodule

/* sim.f */
+incdir+hdl
hdl/utf8sv_pkg.sv
hdl/utf8sv_step.sv
hdl/utf8sv_rsp_reg.sv
hdl/utf8_stream_validator.sv
hdl/utf8sv_checker.sv
bench/tb_top.sv
